### hdl/tspc_pkg.sv
// Shared types, codes and helpers for the tile/sprite pixel compositor.
// Used by tspc_ctrl, tspc_datapath and the top level; depends on nothing.
`default_nettype none
package tspc_pkg;

  localparam int VIDEO_AW = 13;

  // item opcodes
  localparam logic [1:0] OP_WR_VRAM   = 2'd0;
  localparam logic [1:0] OP_WR_SPRITE = 2'd1;
  localparam logic [1:0] OP_RENDER    = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_LCDC  = 3'd0;
  localparam logic [2:0] CFG_SCY   = 3'd1;
  localparam logic [2:0] CFG_SCX   = 3'd2;
  localparam logic [2:0] CFG_BGP   = 3'd3;
  localparam logic [2:0] CFG_OBP0  = 3'd4;
  localparam logic [2:0] CFG_OBP1  = 3'd5;
  localparam logic [2:0] CFG_WY    = 3'd6;
  localparam logic [2:0] CFG_WX    = 3'd7;

  // datapath phases issued by the controller
  localparam logic [3:0] PH_NONE    = 4'd0;
  localparam logic [3:0] PH_WR_VRAM = 4'd1;
  localparam logic [3:0] PH_WR_SPR  = 4'd2;
  localparam logic [3:0] PH_LOAD    = 4'd3;
  localparam logic [3:0] PH_MAP     = 4'd4;
  localparam logic [3:0] PH_LO      = 4'd5;
  localparam logic [3:0] PH_HI      = 4'd6;
  localparam logic [3:0] PH_PIX     = 4'd7;
  localparam logic [3:0] PH_SRD     = 4'd8;
  localparam logic [3:0] PH_SCHK    = 4'd9;
  localparam logic [3:0] PH_SLO     = 4'd10;
  localparam logic [3:0] PH_SPIX    = 4'd11;
  localparam logic [3:0] PH_DONE    = 4'd12;

  // video memory offsets (CPU address minus 0x8000)
  localparam logic [12:0] MAP_LOW_BASE   = 13'h1800;
  localparam logic [12:0] MAP_HIGH_BASE  = 13'h1C00;
  localparam logic [12:0] SIGNED_TILE_BASE = 13'h0800;

  typedef struct packed {
    logic [3:0] phase;
    logic       pass;     // 0 background, 1 window
    logic       spr_inc;
  } tspc_cmd_t;

  typedef struct packed {
    logic bg_en;
    logic win_hit;
    logic spr_go;
    logic spr_hit;
    logic spr_take;
    logic spr_last;
  } tspc_status_t;

  function automatic logic [1:0] pal_pick(input logic [7:0] pal, input logic [1:0] idx);
    logic [1:0] r;
    unique case (idx)
      2'd0: r = pal[1:0];
      2'd1: r = pal[3:2];
      2'd2: r = pal[5:4];
      default: r = pal[7:6];
    endcase
    return r;
  endfunction

  function automatic logic [31:0] grey_word(input logic [1:0] s);
    logic [31:0] r;
    unique case (s)
      2'd0: r = 32'hFFFFFFFF;
      2'd1: r = 32'hFFAAAAAA;
      2'd2: r = 32'hFF555555;
      default: r = 32'hFF000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/tspc_ctrl.sv
// Controller state machine for the compositor: sequences memory fetches.
// Depends on tspc_pkg; drives tspc_datapath through a command struct.
`default_nettype none
module tspc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [1:0]            opcode,
  input  tspc_pkg::tspc_status_t     status,
  output tspc_pkg::tspc_cmd_t        cmd,
  output logic                       busy
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MAP  = 4'd1;
  localparam logic [3:0] ST_LO   = 4'd2;
  localparam logic [3:0] ST_HI   = 4'd3;
  localparam logic [3:0] ST_PIX  = 4'd4;
  localparam logic [3:0] ST_SRD  = 4'd5;
  localparam logic [3:0] ST_SCHK = 4'd6;
  localparam logic [3:0] ST_SLO  = 4'd7;
  localparam logic [3:0] ST_SPIX = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0] state, state_next;
  logic       pass, pass_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pass  <= 1'b0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next  = state;
    pass_next   = pass;
    cmd.phase   = tspc_pkg::PH_NONE;
    cmd.pass    = pass;
    cmd.spr_inc = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          priority case (opcode)
            tspc_pkg::OP_WR_VRAM:   cmd.phase = tspc_pkg::PH_WR_VRAM;
            tspc_pkg::OP_WR_SPRITE: cmd.phase = tspc_pkg::PH_WR_SPR;
            tspc_pkg::OP_RENDER: begin
              cmd.phase  = tspc_pkg::PH_LOAD;
              pass_next  = 1'b0;
              state_next = ST_MAP;
            end
            default: cmd.phase = tspc_pkg::PH_NONE;
          endcase
        end
      end
      ST_MAP: begin
        if (status.bg_en) begin
          cmd.phase  = tspc_pkg::PH_MAP;
          state_next = ST_LO;
        end else begin
          state_next = status.spr_go ? ST_SRD : ST_DONE;
        end
      end
      ST_LO: begin
        cmd.phase  = tspc_pkg::PH_LO;
        state_next = ST_HI;
      end
      ST_HI: begin
        cmd.phase  = tspc_pkg::PH_HI;
        state_next = ST_PIX;
      end
      ST_PIX: begin
        cmd.phase = tspc_pkg::PH_PIX;
        if (!pass && status.win_hit) begin
          pass_next  = 1'b1;
          state_next = ST_MAP;
        end else begin
          state_next = status.spr_go ? ST_SRD : ST_DONE;
        end
      end
      ST_SRD: begin
        cmd.phase  = tspc_pkg::PH_SRD;
        state_next = ST_SCHK;
      end
      ST_SCHK: begin
        cmd.phase = tspc_pkg::PH_SCHK;
        if (status.spr_hit) begin
          state_next = ST_SLO;
        end else if (status.spr_last) begin
          state_next = ST_DONE;
        end else begin
          cmd.spr_inc = 1'b1;
          state_next  = ST_SRD;
        end
      end
      ST_SLO: begin
        cmd.phase  = tspc_pkg::PH_SLO;
        state_next = ST_SPIX;
      end
      ST_SPIX: begin
        cmd.phase = tspc_pkg::PH_SPIX;
        if (status.spr_take || status.spr_last) begin
          state_next = ST_DONE;
        end else begin
          cmd.spr_inc = 1'b1;
          state_next  = ST_SRD;
        end
      end
      ST_DONE: begin
        cmd.phase  = tspc_pkg::PH_DONE;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### hdl/tspc_datapath.sv
// Datapath of the compositor: registers, video memory, sprite table,
// address generation and shade selection. Depends on tspc_pkg.
`default_nettype none
module tspc_datapath #(
  parameter int SPRITE_COUNT = 40,
  parameter int SCREEN_WIDTH = 160
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  tspc_pkg::tspc_cmd_t        cmd,
  output tspc_pkg::tspc_status_t     status,
  input  wire logic [12:0]           mem_address,
  input  wire logic [7:0]            mem_data,
  input  wire logic [7:0]            pixel_column,
  input  wire logic [7:0]            screen_line,
  input  wire logic                  cfg_write,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [7:0]            cfg_data,
  output logic                       done,
  output logic [1:0]                 shade,
  output logic [31:0]                argb_color
);

  localparam int SPW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
  localparam int VIDEO_DEPTH = 1 << tspc_pkg::VIDEO_AW;

  logic [7:0] lcdc, scy, scx, bgp, obp0, obp1, wy, wx;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcdc <= 8'h91;
      scy  <= 8'h00;
      scx  <= 8'h00;
      bgp  <= 8'hFC;
      obp0 <= 8'hFF;
      obp1 <= 8'hFF;
      wy   <= 8'h00;
      wx   <= 8'h00;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tspc_pkg::CFG_LCDC: lcdc <= cfg_data;
        tspc_pkg::CFG_SCY:  scy  <= cfg_data;
        tspc_pkg::CFG_SCX:  scx  <= cfg_data;
        tspc_pkg::CFG_BGP:  bgp  <= cfg_data;
        tspc_pkg::CFG_OBP0: obp0 <= cfg_data;
        tspc_pkg::CFG_OBP1: obp1 <= cfg_data;
        tspc_pkg::CFG_WY:   wy   <= cfg_data;
        default:            wx   <= cfg_data;
      endcase
    end
  end

  // render item coordinates and working values
  logic [7:0]     col, line;
  logic [1:0]     cid, shade_acc;
  logic [12:0]    loc;
  logic [7:0]     lo_byte;
  logic [2:0]     sbit;
  logic [7:0]     sattr;
  logic [SPW-1:0] sp;

  // video memory, one port
  logic [7:0]  vram [VIDEO_DEPTH];
  logic [7:0]  vram_q;
  logic [12:0] vram_raddr;

  always_ff @(posedge clk) begin
    if (cmd.phase == tspc_pkg::PH_WR_VRAM) begin
      vram[mem_address] <= mem_data;
    end else begin
      vram_q <= vram[vram_raddr];
    end
  end

  // sprite table, one byte lane per attribute
  logic [7:0] spr_y [SPRITE_COUNT];
  logic [7:0] spr_x [SPRITE_COUNT];
  logic [7:0] spr_t [SPRITE_COUNT];
  logic [7:0] spr_a [SPRITE_COUNT];
  logic [7:0] ey, ex, et, ea;
  logic       spr_wr_ok;

  assign spr_wr_ok = (mem_address < 13'(4 * SPRITE_COUNT));

  always_ff @(posedge clk) begin
    if (cmd.phase == tspc_pkg::PH_WR_SPR && spr_wr_ok) begin
      unique case (mem_address[1:0])
        2'd0: spr_y[mem_address[SPW+1:2]] <= mem_data;
        2'd1: spr_x[mem_address[SPW+1:2]] <= mem_data;
        2'd2: spr_t[mem_address[SPW+1:2]] <= mem_data;
        default: spr_a[mem_address[SPW+1:2]] <= mem_data;
      endcase
    end
    ey <= spr_y[sp];
    ex <= spr_x[sp];
    et <= spr_t[sp];
    ea <= spr_a[sp];
  end

  // map coordinates for the current pass
  logic [7:0]  mx, my;
  logic [8:0]  col7;
  logic [12:0] map_addr, tile_loc;
  logic [7:0]  tid;

  assign col7 = {1'b0, col} + 9'd7;

  always_comb begin
    if (cmd.pass) begin
      mx = 8'(col7 - {1'b0, wx});
      my = line - wy;
      map_addr = (lcdc[6] ? tspc_pkg::MAP_HIGH_BASE : tspc_pkg::MAP_LOW_BASE)
                 | {3'b000, my[7:3], mx[7:3]};
    end else begin
      mx = col + scx;
      my = line + scy;
      map_addr = (lcdc[3] ? tspc_pkg::MAP_HIGH_BASE : tspc_pkg::MAP_LOW_BASE)
                 | {3'b000, my[7:3], mx[7:3]};
    end
    tid = vram_q;
    if (lcdc[4]) begin
      tile_loc = {1'b0, tid, my[2:0], 1'b0};
    end else begin
      tile_loc = tspc_pkg::SIGNED_TILE_BASE + {1'b0, tid ^ 8'h80, my[2:0], 1'b0};
    end
  end

  // sprite hit test on the fetched entry
  logic       tall;
  logic [9:0] rowd, xod;
  logic [3:0] rowf;
  logic [7:0] tile_eff;
  logic [12:0] spr_loc;
  logic [2:0] spr_bit;
  logic       spr_hit;

  assign tall = lcdc[2];

  always_comb begin
    rowd = {2'b00, line} + 10'd16 - {2'b00, ey};
    xod  = {2'b00, col} + 10'd8 - {2'b00, ex};
    spr_hit = !rowd[9] && (rowd < (tall ? 10'd16 : 10'd8)) && !xod[9] && (xod < 10'd8);
    if (ea[6]) begin
      rowf = (tall ? 4'd15 : 4'd7) - rowd[3:0];
    end else begin
      rowf = rowd[3:0];
    end
    tile_eff = tall ? {et[7:1], rowf[3]} : et;
    spr_loc  = {1'b0, tile_eff, rowf[2:0], 1'b0};
    spr_bit  = ea[5] ? xod[2:0] : ~xod[2:0];
  end

  // read address: tile rows are even, so the high byte sets bit 0
  always_comb begin
    unique case (cmd.phase)
      tspc_pkg::PH_MAP:  vram_raddr = map_addr;
      tspc_pkg::PH_LO:   vram_raddr = tile_loc;
      tspc_pkg::PH_SCHK: vram_raddr = spr_loc;
      default:           vram_raddr = {loc[12:1], 1'b1};
    endcase
  end

  logic [1:0] bg_px, spr_px;
  logic       spr_take;

  assign bg_px    = {vram_q[~mx[2:0]], lo_byte[~mx[2:0]]};
  assign spr_px   = {vram_q[sbit], lo_byte[sbit]};
  assign spr_take = (spr_px != 2'd0) && !(sattr[7] && cid != 2'd0);

  always_ff @(posedge clk) begin
    unique case (cmd.phase)
      tspc_pkg::PH_LOAD: begin
        col       <= pixel_column;
        line      <= screen_line;
        cid       <= 2'd0;
        shade_acc <= 2'd0;
      end
      tspc_pkg::PH_LO: loc <= tile_loc;
      tspc_pkg::PH_HI, tspc_pkg::PH_SLO: lo_byte <= vram_q;
      tspc_pkg::PH_PIX: begin
        cid       <= bg_px;
        shade_acc <= tspc_pkg::pal_pick(bgp, bg_px);
      end
      tspc_pkg::PH_SCHK: begin
        loc   <= spr_loc;
        sbit  <= spr_bit;
        sattr <= ea;
      end
      tspc_pkg::PH_SPIX: begin
        if (spr_take) begin
          shade_acc <= tspc_pkg::pal_pick(sattr[4] ? obp1 : obp0, spr_px);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.phase == tspc_pkg::PH_LOAD) begin
      sp <= '0;
    end else if (cmd.spr_inc) begin
      sp <= sp + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.phase == tspc_pkg::PH_DONE);
    end
    if (cmd.phase == tspc_pkg::PH_DONE) begin
      shade      <= shade_acc;
      argb_color <= tspc_pkg::grey_word(shade_acc);
    end
  end

  always_comb begin
    status.bg_en    = lcdc[0];
    status.win_hit  = lcdc[5] && (line >= wy) && (col7 >= {1'b0, wx});
    status.spr_go   = lcdc[1] && ({1'b0, col} < 9'(SCREEN_WIDTH));
    status.spr_hit  = spr_hit;
    status.spr_take = spr_take;
    status.spr_last = (sp == SPW'(SPRITE_COUNT - 1));
  end

endmodule
`default_nettype wire

### hdl/tile_sprite_pixel_compositor.sv
// Top level of the tile map and sprite pixel compositor.
// Depends on tspc_pkg, tspc_ctrl and tspc_datapath.
// Write items (video memory, sprite table) give no result. A render item
// loads its coordinates, fetches the map entry and tile bytes for the
// background when enabled, again for the window when it covers the pixel,
// then reads and checks each sprite entry (with its tile bytes when it
// covers the pixel) until the winning sprite or the last of SPRITE_COUNT
// entries. busy is high while a render item is at work. The shade appears
// on shade and argb_color with done high for exactly one cycle; the
// receiver cannot stall it.
`default_nettype none
module tile_sprite_pixel_compositor #(
  parameter int SPRITE_COUNT = 40,
  parameter int SCREEN_WIDTH = 160
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode,
  input  wire logic [12:0] mem_address,
  input  wire logic [7:0]  mem_data,
  input  wire logic [7:0]  pixel_column,
  input  wire logic [7:0]  screen_line,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  output logic             done,
  output logic [1:0]       shade,
  output logic [31:0]      argb_color
);

  tspc_pkg::tspc_cmd_t    cmd;
  tspc_pkg::tspc_status_t status;

  tspc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  tspc_datapath #(
    .SPRITE_COUNT (SPRITE_COUNT),
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .mem_address  (mem_address),
    .mem_data     (mem_data),
    .pixel_column (pixel_column),
    .screen_line  (screen_line),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .shade        (shade),
    .argb_color   (argb_color)
  );

endmodule
`default_nettype wire
